[hw/rtl/pds_pkg.sv]
// Package for the pass dependency scheduler: parameter defaults, result kind
// codes and the controller/datapath command and status structs. No dependencies.
`default_nettype none
package pds_pkg;
  localparam int DEF_MAX_PASSES    = 32;
  localparam int DEF_NUM_RESOURCES = 32;

  localparam logic [1:0] KIND_ORDER    = 2'd0;
  localparam logic [1:0] KIND_LIFETIME = 2'd1;
  localparam logic [1:0] KIND_CYCLE    = 2'd2;
  localparam logic [1:0] KIND_OVERFLOW = 2'd3;

  typedef struct packed {
    logic load;
    logic init_scan;
    logic pop;
    logic rel;
    logic life_init;
    logic life;
    logic emit_ovf;
    logic emit_cyc;
    logic emit_ord;
    logic res_step;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic last_j;
    logic last_pos;
    logic last_r;
    logic touch_r;
    logic none_touched;
    logic queue_empty;
    logic all_sorted;
    logic ovf_now;
    logic out_busy;
  } stat_t;
endpackage
`default_nettype wire

[hw/rtl/pds_if.sv]
// Stream interfaces of the pass dependency scheduler: pass beats in, result beats out.
// Uses no package.
`default_nettype none
interface pds_pass_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_mask;
  logic [31:0] write_mask;
  logic        last_pass;
  modport source(output valid, read_mask, write_mask, last_pass, input ready);
  modport sink(input valid, read_mask, write_mask, last_pass, output ready);
endinterface

interface pds_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [4:0] pass_index;
  logic [4:0] resource_index;
  logic [5:0] first_write;
  logic [5:0] last_read;
  logic [5:0] sorted_count;
  logic       last;
  modport source(output valid, kind, pass_index, resource_index, first_write, last_read,
                 sorted_count, last, input ready);
  modport sink(input valid, kind, pass_index, resource_index, first_write, last_read,
               sorted_count, last, output ready);
endinterface
`default_nettype wire

[hw/rtl/pds_datapath.sv]
// Datapath of the pass dependency scheduler: pass tables, predecessor rows,
// ready queue, lifetime tables and result register. Depends on pds_pkg.
`default_nettype none
module pds_datapath #(
  parameter int MAX_PASSES    = pds_pkg::DEF_MAX_PASSES,
  parameter int NUM_RESOURCES = pds_pkg::DEF_NUM_RESOURCES
) (
  input  logic           clk,
  input  logic           rst,
  input  pds_pkg::cmd_t  cmd,
  output pds_pkg::stat_t stat,
  input  logic [31:0]    read_mask,
  input  logic [31:0]    write_mask,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     kind,
  output logic [4:0]     pass_index,
  output logic [4:0]     resource_index,
  output logic [5:0]     first_write,
  output logic [5:0]     last_read,
  output logic [5:0]     sorted_count,
  output logic           last
);
  localparam int NR = (NUM_RESOURCES > 32) ? 32 : NUM_RESOURCES;
  localparam int IW = $clog2(MAX_PASSES);
  localparam int CW = $clog2(MAX_PASSES + 1);
  localparam int RW = (NR > 1) ? $clog2(NR) : 1;

  logic [NR-1:0]         pass_reads [MAX_PASSES];
  logic [NR-1:0]         pass_writes [MAX_PASSES];
  logic [MAX_PASSES-1:0] pred [MAX_PASSES];
  logic [IW-1:0]         queue [MAX_PASSES];
  logic [IW-1:0]         last_writer [NR];
  logic [NR-1:0]         writer_valid;
  logic [CW-1:0]         count, head, tail;
  logic                  ovf;
  logic [IW-1:0]         j, cur, pos;
  logic [RW-1:0]         r;
  logic [5:0]            fw [NR];
  logic [5:0]            lr [NR];
  logic [NR-1:0]         fw_set, touched;

  logic [NR-1:0]         rd, wr, pr, pw;
  logic [MAX_PASSES-1:0] dep, pred_j, cur_bit, pred_j_rel;
  logic [IW-1:0]         idx, p;

  function automatic logic [1:0] KIND_SEL(input pds_pkg::cmd_t c);
    logic [1:0] k;
    k = pds_pkg::KIND_ORDER;
    if (c.emit_ovf) k = pds_pkg::KIND_OVERFLOW;
    else if (c.emit_cyc) k = pds_pkg::KIND_CYCLE;
    else if (c.res_step) k = pds_pkg::KIND_LIFETIME;
    return k;
  endfunction

  assign rd      = read_mask[NR-1:0];
  assign wr      = write_mask[NR-1:0];
  assign idx     = count[IW-1:0];
  assign pred_j  = pred[j];
  assign p       = queue[pos];
  assign pr      = pass_reads[p];
  assign pw      = pass_writes[p];

  always_comb begin
    dep     = '0;
    cur_bit = '0;
    for (int k = 0; k < NR; k++) begin
      if ((rd[k] || wr[k]) && writer_valid[k]) begin
        dep[last_writer[k]] = 1'b1;
      end
    end
    cur_bit[cur] = 1'b1;
    pred_j_rel   = pred_j & ~cur_bit;
  end

  always_comb begin
    stat.last_j       = (CW'(j) + CW'(1)) == count;
    stat.last_pos     = (CW'(pos) + CW'(1)) == count;
    stat.last_r       = r == RW'(NR - 1);
    stat.touch_r      = touched[r];
    stat.none_touched = touched == '0;
    stat.queue_empty  = head == tail;
    stat.all_sorted   = tail == count;
    stat.ovf_now      = ovf || (count == CW'(MAX_PASSES));
    stat.out_busy     = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !stat.ovf_now) begin
      pass_reads[idx]  <= rd;
      pass_writes[idx] <= wr;
      pred[idx]        <= dep;
      for (int k = 0; k < NR; k++) begin
        if (wr[k]) begin
          last_writer[k] <= idx;
        end
      end
    end
    if (cmd.init_scan && pred_j == '0) begin
      queue[tail[IW-1:0]] <= j;
    end
    if (cmd.pop) begin
      cur <= queue[head[IW-1:0]];
    end
    if (cmd.rel && pred_j[cur]) begin
      pred[j] <= pred_j_rel;
      if (pred_j_rel == '0) begin
        queue[tail[IW-1:0]] <= j;
      end
    end
    if (cmd.life) begin
      for (int k = 0; k < NR; k++) begin
        if (pw[k] && !fw_set[k]) begin
          fw[k] <= 6'(pos);
        end
        if (pr[k]) begin
          lr[k] <= 6'(pos);
        end
      end
    end
    if (cmd.life_init) begin
      for (int k = 0; k < NR; k++) begin
        lr[k] <= 6'h3F;
      end
    end
    if (cmd.emit_ovf || cmd.emit_cyc || cmd.emit_ord || (cmd.res_step && stat.touch_r)) begin
      kind           <= KIND_SEL(cmd);
      pass_index     <= cmd.emit_ord ? 5'(p) : 5'd0;
      resource_index <= (cmd.res_step) ? 5'(r) : 5'd0;
      first_write    <= (cmd.res_step) ? (fw_set[r] ? fw[r] : 6'h3F) : 6'd0;
      last_read      <= (cmd.res_step) ? lr[r] : 6'd0;
      sorted_count   <= cmd.emit_cyc ? 6'(tail) : 6'd0;
      last           <= cmd.emit_ovf || cmd.emit_cyc ||
                        (cmd.emit_ord && stat.none_touched && stat.last_pos) ||
                        (cmd.res_step && (((touched >> r) >> 1) == '0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      ovf          <= 1'b0;
      writer_valid <= '0;
      head         <= '0;
      tail         <= '0;
      j            <= '0;
      pos          <= '0;
      r            <= '0;
      fw_set       <= '0;
      touched      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.emit_ovf || cmd.emit_cyc || cmd.emit_ord || (cmd.res_step && stat.touch_r)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        if (stat.ovf_now) begin
          ovf <= 1'b1;
        end else begin
          writer_valid <= writer_valid | wr;
          count        <= count + CW'(1);
        end
      end
      if (cmd.init_scan || cmd.rel) begin
        j <= stat.last_j ? '0 : j + IW'(1);
      end
      if ((cmd.init_scan && pred_j == '0) || (cmd.rel && pred_j[cur] && pred_j_rel == '0)) begin
        tail <= tail + CW'(1);
      end
      if (cmd.pop) begin
        head <= head + CW'(1);
        j    <= '0;
      end
      if (cmd.life_init) begin
        fw_set  <= '0;
        touched <= '0;
        pos     <= '0;
        r       <= '0;
      end
      if (cmd.life) begin
        touched <= touched | pr | pw;
        fw_set  <= fw_set | pw;
      end
      if (cmd.life || cmd.emit_ord) begin
        pos <= stat.last_pos ? '0 : pos + IW'(1);
      end
      if (cmd.res_step) begin
        r <= stat.last_r ? '0 : r + RW'(1);
      end
      if (cmd.clear) begin
        count        <= '0;
        ovf          <= 1'b0;
        writer_valid <= '0;
        head         <= '0;
        tail         <= '0;
        j            <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_head_tail: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("queue head passed tail");
  a_tail_count: assert property (@(posedge clk) disable iff (rst) tail <= count)
    else $error("more passes queued than loaded");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (count == '0) && !ovf && (writer_valid == '0))
    else $error("run state not cleared");
`endif
endmodule
`default_nettype wire

[hw/rtl/pds_ctrl.sv]
// Controller of the pass dependency scheduler: sequences load, sort, lifetime
// scan and result emission. Depends on pds_pkg.
`default_nettype none
module pds_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  input  pds_pkg::stat_t stat,
  output pds_pkg::cmd_t  cmd
);
  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_OVF   = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_POP   = 4'd3;
  localparam logic [3:0] S_REL   = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_CYC   = 4'd6;
  localparam logic [3:0] S_LIFE  = 4'd7;
  localparam logic [3:0] S_ORD   = 4'd8;
  localparam logic [3:0] S_RES   = 4'd9;
  localparam logic [3:0] S_CLR   = 4'd10;

  logic [3:0] state, state_next;

  assign in_ready = state == S_LOAD;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_next = stat.ovf_now ? S_OVF : S_INIT;
        end
      end
      S_OVF: begin
        if (!stat.out_busy) begin
          cmd.emit_ovf = 1'b1;
          state_next   = S_CLR;
        end
      end
      S_INIT: begin
        cmd.init_scan = 1'b1;
        if (stat.last_j) state_next = S_POP;
      end
      S_POP: begin
        if (stat.queue_empty) begin
          state_next = S_CHECK;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_REL;
        end
      end
      S_REL: begin
        cmd.rel = 1'b1;
        if (stat.last_j) state_next = S_POP;
      end
      S_CHECK: begin
        if (!stat.all_sorted) begin
          state_next = S_CYC;
        end else begin
          cmd.life_init = 1'b1;
          state_next    = S_LIFE;
        end
      end
      S_CYC: begin
        if (!stat.out_busy) begin
          cmd.emit_cyc = 1'b1;
          state_next   = S_CLR;
        end
      end
      S_LIFE: begin
        cmd.life = 1'b1;
        if (stat.last_pos) state_next = S_ORD;
      end
      S_ORD: begin
        if (!stat.out_busy) begin
          cmd.emit_ord = 1'b1;
          if (stat.last_pos) state_next = stat.none_touched ? S_CLR : S_RES;
        end
      end
      S_RES: begin
        if (!stat.touch_r || !stat.out_busy) begin
          cmd.res_step = 1'b1;
          if (stat.last_r) state_next = S_CLR;
        end
      end
      S_CLR: begin
        cmd.clear  = 1'b1;
        state_next = S_LOAD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/pass_dependency_scheduler.sv]
// Top level of the pass dependency scheduler: controller plus datapath.
// Depends on pds_pkg, pds_if, pds_ctrl and pds_datapath.
//
// Passes load at one beat per cycle; each one that fits in the tables updates
// the last-writer table and stores its predecessor row. After the beat marked
// last_pass the controller runs a stable Kahn sort: an initial scan over every
// loaded pass, then per popped pass a release scan over every loaded pass. A
// lifetime scan over the sorted passes follows, then n order beats for n passes
// and one beat per touched resource (every resource index is scanned), each
// waiting on result ready. A cycle or overflow yields a single result beat. No
// pass beat is taken from the last_pass beat until the run's results are all
// issued.
`default_nettype none
module pass_dependency_scheduler #(
  parameter int MAX_PASSES    = pds_pkg::DEF_MAX_PASSES,
  parameter int NUM_RESOURCES = pds_pkg::DEF_NUM_RESOURCES
) (
  input logic                clk,
  input logic                rst,
  pds_pass_if.sink           pass_in,
  pds_result_if.source       result_out
);
  pds_pkg::cmd_t  cmd;
  pds_pkg::stat_t stat;

  pds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pass_in.valid),
    .in_last  (pass_in.last_pass),
    .in_ready (pass_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pds_datapath #(
    .MAX_PASSES    (MAX_PASSES),
    .NUM_RESOURCES (NUM_RESOURCES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .read_mask      (pass_in.read_mask),
    .write_mask     (pass_in.write_mask),
    .out_valid      (result_out.valid),
    .out_ready      (result_out.ready),
    .kind           (result_out.kind),
    .pass_index     (result_out.pass_index),
    .resource_index (result_out.resource_index),
    .first_write    (result_out.first_write),
    .last_read      (result_out.last_read),
    .sorted_count   (result_out.sorted_count),
    .last           (result_out.last)
  );
endmodule
`default_nettype wire
